// File: src/tdcf_pkg.sv
// Shared widths, register codes, status codes and types of the TDC time-of-flight calculator.
package tdcf_pkg;

    localparam int PERIOD_W  = 20;
    localparam int CODE_W    = 2;
    localparam int STOP_W    = 3;
    localparam int FINE_W    = 24;
    localparam int COARSE_W  = 16;
    localparam int LEN_W     = 6;
    localparam int SCALE_W   = PERIOD_W + LEN_W;
    localparam int PROD_W    = SCALE_W + FINE_W;
    localparam int CTERM_W   = COARSE_W + PERIOD_W;
    localparam int TOF_W     = 48;
    localparam int SUM_W     = PROD_W + 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = PERIOD_W;
    localparam int MAX_STOPS = 5;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // request bit positions
    localparam int CAL1_LSB   = 0;
    localparam int CAL2_LSB   = CAL1_LSB + FINE_W;
    localparam int START_LSB  = CAL2_LSB + FINE_W;
    localparam int STOP_LSB   = START_LSB + FINE_W;
    localparam int COARSE_LSB = STOP_LSB + FINE_W;
    localparam int IDX_LSB    = COARSE_LSB + COARSE_W;
    localparam int COVF_BIT   = IDX_LSB + STOP_W;
    localparam int KOVF_BIT   = COVF_BIT + 1;
    localparam int IN_W       = KOVF_BIT + 1;
    localparam int S_DATA_W   = ((IN_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((TOF_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOPS  = 2'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd83333;
    localparam logic [CODE_W-1:0]   CAL_RST    = 2'd1;
    localparam logic                MODE_RST   = 1'b1;
    localparam logic [STOP_W-1:0]   STOPS_RST  = 3'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CAL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVF = 2'd2;

    localparam logic [TOF_W-1:0] TOF_MAX = {1'b0, {(TOF_W-1){1'b1}}};
    localparam logic [TOF_W-1:0] TOF_MIN = {1'b1, {(TOF_W-1){1'b0}}};

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [CODE_W-1:0]   cal_code;
        logic                mode_two;
        logic [STOP_W-1:0]   stop_count;
    } cfg_t;

    typedef struct packed {
        logic [CTERM_W-1:0]  coarse_term;
        logic                neg;
        logic                bad;
        logic [STATUS_W-1:0] status;
        logic                last;
    } side_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [FINE_W-1:0]  mag;
        logic [FINE_W-1:0]  den;
        side_t              side;
    } job_t;

    // calibration length minus one
    function automatic logic [LEN_W-1:0] cal_len_m1(input logic [CODE_W-1:0] code);
        logic [LEN_W-1:0] len;
        unique case (code)
            2'd0:    len = 6'd1;
            2'd1:    len = 6'd9;
            2'd2:    len = 6'd19;
            default: len = 6'd39;
        endcase
        return len;
    endfunction

endpackage

// File: src/tdcf_front.sv
// Front end: accepts a stop request, classifies it and forms the scale, magnitude and coarse term.
module tdcf_front
    import tdcf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [S_DATA_W-1:0] in_data,
    output logic                job_valid,
    input  logic                job_ready,
    output job_t                job
);

    logic               front_v_reg;
    job_t               job_reg;
    job_t               job_next;

    logic [FINE_W-1:0]   cal1, cal2, t_start, t_stop;
    logic [COARSE_W-1:0] coarse;
    logic [STOP_W-1:0]   idx, nstops;
    logic                ovf, bad;

    always_comb
    begin
        cal1    = in_data[CAL1_LSB +: FINE_W];
        cal2    = in_data[CAL2_LSB +: FINE_W];
        t_start = in_data[START_LSB +: FINE_W];
        t_stop  = in_data[STOP_LSB +: FINE_W];
        coarse  = in_data[COARSE_LSB +: COARSE_W];
        idx     = in_data[IDX_LSB +: STOP_W];
        ovf     = in_data[COVF_BIT] | in_data[KOVF_BIT];
        bad     = (cal2 <= cal1);

        if (cfg.stop_count == '0 || cfg.stop_count > STOP_W'(MAX_STOPS))
            nstops = STOP_W'(1);
        else
            nstops = cfg.stop_count;

        job_next.scale = SCALE_W'(cfg.period) * SCALE_W'(cal_len_m1(cfg.cal_code));
        job_next.den   = cal2 - cal1;
        if (cfg.mode_two)
        begin
            job_next.side.neg = (t_start < t_stop);
            job_next.mag      = (t_start < t_stop) ? (t_stop - t_start) : (t_start - t_stop);
            job_next.side.coarse_term = CTERM_W'(coarse) * CTERM_W'(cfg.period);
        end
        else
        begin
            job_next.side.neg         = 1'b0;
            job_next.mag              = t_stop;
            job_next.side.coarse_term = '0;
        end
        job_next.side.bad    = bad;
        job_next.side.status = bad ? STATUS_CAL : (ovf ? STATUS_OVF : STATUS_OK);
        job_next.side.last   = (idx == nstops - STOP_W'(1));
    end

    assign in_ready  = !front_v_reg || job_ready;
    assign job_valid = front_v_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_v_reg <= 1'b0;
        else if (in_ready)
            front_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            job_reg <= job_next;
    end

endmodule

// File: src/tdcf_queue.sv
// Short queue between the front end and the arithmetic back end.
module tdcf_queue
    import tdcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push, pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count missed a push");

endmodule

// File: src/tdcf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tdcf_div
    import tdcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [PROD_W-1:0] in_prod,
    input  logic [FINE_W-1:0] in_den,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [PROD_W-1:0] out_quo,
    output side_t             out_side
);

    localparam int DIV_STEPS = PROD_W;

    logic              v_reg    [DIV_STEPS];
    logic [FINE_W-1:0] rem_reg  [DIV_STEPS];
    logic [PROD_W-1:0] work_reg [DIV_STEPS];
    logic [FINE_W-1:0] den_reg  [DIV_STEPS];
    side_t             side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic              v_in;
        logic [FINE_W-1:0] rem_in, den_in, rem_next;
        logic [PROD_W-1:0] work_in, work_next;
        side_t             side_in;
        logic [FINE_W:0]   trial;
        logic              qbit;

        if (k == 0)
        begin : g_head
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign work_in = in_prod;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else
        begin : g_body
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign work_in = work_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, work_in[PROD_W-1]};
            qbit  = (trial >= {1'b0, den_in});
            if (qbit)
                rem_next = FINE_W'(trial - {1'b0, den_in});
            else
                rem_next = trial[FINE_W-1:0];
            work_next = {work_in[PROD_W-2:0], qbit};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_quo   = work_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

// File: src/tdcf_back.sv
// Back end: scale product, divider pipeline, coarse add, saturation and output register.
module tdcf_back
    import tdcf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  job_t                job,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0] m_tuser,
    output logic                m_tlast
);

    logic              en;
    logic              mv_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [FINE_W-1:0] den_reg;
    side_t             side_reg;

    logic              dv;
    logic [PROD_W-1:0] quo;
    side_t             dside;

    logic [SUM_W-1:0]  sum;
    logic              fits;
    logic [TOF_W-1:0]  tof_next;

    logic                out_valid_reg;
    logic [TOF_W-1:0]    tof_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    assign en        = !out_valid_reg || m_tready;
    assign job_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (en)
            mv_reg <= job_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(job.scale) * PROD_W'(job.mag);
            den_reg  <= job.den;
            side_reg <= job.side;
        end
    end

    tdcf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mv_reg),
        .in_prod   (prod_reg),
        .in_den    (den_reg),
        .in_side   (side_reg),
        .out_valid (dv),
        .out_quo   (quo),
        .out_side  (dside)
    );

    always_comb
    begin
        if (dside.neg)
            sum = SUM_W'(dside.coarse_term) - SUM_W'(quo);
        else
            sum = SUM_W'(dside.coarse_term) + SUM_W'(quo);
        fits = (sum[SUM_W-1:TOF_W-1] == '0) || (sum[SUM_W-1:TOF_W-1] == '1);
        if (dside.bad)
            tof_next = '0;
        else if (fits)
            tof_next = sum[TOF_W-1:0];
        else
            tof_next = sum[SUM_W-1] ? TOF_MIN : TOF_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tof_reg    <= tof_next;
            status_reg <= dside.status;
            last_reg   <= dside.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(tof_reg);
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_CAL) |-> tof_reg == '0)
        else $error("bad calibration result carries a nonzero time");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (mv_reg == $past(mv_reg)) && (dv == $past(dv)))
        else $error("back pipeline moved while output stalled");

endmodule

// File: src/tdc_time_of_flight_calc.sv
// Top level of the calibrated TDC time-of-flight calculator.
//
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  s_tdata: stop request fields
//  m_*       out   m_tvalid/m_tready  m_tdata: tof_ps, m_tuser: status, m_tlast: last_stop
//  cfg_*     in    cfg_we             cfg_index, cfg_data
//
//  One request per cycle sustained while m_tready is high. Path: front register, queue,
//  product register, 50-stage divider (one quotient bit per stage), output register.
//  Reset clears all valid bits and loads the register defaults; no clearing pass.
//  m_tready low freezes the back pipeline; the 4-entry queue and the front
//  register then fill before s_tready drops.
module tdc_time_of_flight_calc
    import tdcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cal_first, cal_second, time_start, time_stop, coarse_count, stop_index,
    // coarse_overflow, clock_overflow, zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tof_ps
    output logic [M_DATA_W-1:0]  m_tdata,
    // status
    output logic [STATUS_W-1:0]  m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t cfg_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    job_t f_job, q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period     <= PERIOD_RST;
            cfg_reg.cal_code   <= CAL_RST;
            cfg_reg.mode_two   <= MODE_RST;
            cfg_reg.stop_count <= STOPS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD: cfg_reg.period     <= cfg_data[PERIOD_W-1:0];
                REG_CAL:    cfg_reg.cal_code   <= cfg_data[CODE_W-1:0];
                REG_MODE:   cfg_reg.mode_two   <= cfg_data[0];
                REG_STOPS:  cfg_reg.stop_count <= cfg_data[STOP_W-1:0];
                default:    ;
            endcase
        end
    end

    tdcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    tdcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    tdcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: test/tdc_time_of_flight_calc_test.sv
// Self-checking testbench of the TDC time-of-flight calculator: directed and random stop requests.
module tdc_time_of_flight_calc_test;
    import tdcf_pkg::*;

    localparam int          SETTLE_CYCLES  = 64;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int unsigned FINE_MAX       = (1 << FINE_W) - 1;
    localparam longint      TOF_HI         = 64'sh7FFF_FFFF_FFFF;
    localparam longint      TOF_LO         = -64'sh8000_0000_0000;

    typedef struct packed {
        logic [FINE_W-1:0]   cal_first;
        logic [FINE_W-1:0]   cal_second;
        logic [FINE_W-1:0]   time_start;
        logic [FINE_W-1:0]   time_stop;
        logic [COARSE_W-1:0] coarse_count;
        logic [STOP_W-1:0]   stop_index;
        logic                coarse_ovf;
        logic                clock_ovf;
    } stop_req_t;

    typedef struct packed {
        logic [TOF_W-1:0]    tof_ps;
        logic [STATUS_W-1:0] status;
        logic                last_stop;
    } tof_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // register copies
    logic [PERIOD_W-1:0]  period_r;
    logic [CODE_W-1:0]    cal_code_r;
    logic                 mode_two_r;
    logic [STOP_W-1:0]    stop_count_r;

    tof_result_t          pending_tofs[$];
    int                   mismatches = 0;
    int                   stall_cycles = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    tdc_time_of_flight_calc uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tof_result_t predict_tof(input stop_req_t r);
        tof_result_t       res;
        longint unsigned   scale;
        longint unsigned   mag;
        longint unsigned   den;
        longint unsigned   q;
        longint            tof;
        logic [STOP_W-1:0] nstops;
        logic              neg;
        nstops = stop_count_r;
        if (nstops == 0 || nstops > MAX_STOPS)
            nstops = STOP_W'(1);
        tof = 0;
        neg = 1'b0;
        if (r.cal_second <= r.cal_first)
        begin
            res.status = STATUS_CAL;
        end
        else
        begin
            den = 64'(r.cal_second - r.cal_first);
            // calibration length minus one
            case (cal_code_r)
                2'd0:    scale = 1;
                2'd1:    scale = 9;
                2'd2:    scale = 19;
                default: scale = 39;
            endcase
            scale = scale * 64'(period_r);
            if (!mode_two_r)
                mag = 64'(r.time_stop);
            else if (r.time_start >= r.time_stop)
                mag = 64'(r.time_start - r.time_stop);
            else
            begin
                mag = 64'(r.time_stop - r.time_start);
                neg = 1'b1;
            end
            q = (scale * mag) / den;
            tof = neg ? -longint'(q) : longint'(q);
            if (mode_two_r)
                tof += longint'(r.coarse_count) * longint'(period_r);
            res.status = (r.coarse_ovf || r.clock_ovf) ? STATUS_OVF : STATUS_OK;
        end
        if (tof > TOF_HI)
            tof = TOF_HI;
        else if (tof < TOF_LO)
            tof = TOF_LO;
        res.tof_ps = tof[TOF_W-1:0];
        res.last_stop = (r.stop_index == nstops - STOP_W'(1));
        return res;
    endfunction

    function automatic stop_req_t make_stop(
        input logic [FINE_W-1:0] cal1, input logic [FINE_W-1:0] cal2,
        input logic [FINE_W-1:0] t_start, input logic [FINE_W-1:0] t_stop,
        input logic [COARSE_W-1:0] coarse, input logic [STOP_W-1:0] idx,
        input logic covf, input logic kovf);
        stop_req_t r;
        r.cal_first = cal1;
        r.cal_second = cal2;
        r.time_start = t_start;
        r.time_stop = t_stop;
        r.coarse_count = coarse;
        r.stop_index = idx;
        r.coarse_ovf = covf;
        r.clock_ovf = kovf;
        return r;
    endfunction

    function automatic logic [FINE_W-1:0] random_fine();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return FINE_W'($urandom);
    endfunction

    function automatic stop_req_t random_stop();
        stop_req_t   r;
        int unsigned den;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            // calibration difference not positive
            r.cal_first = FINE_W'($urandom);
            r.cal_second = FINE_W'($urandom_range(0, r.cal_first));
        end
        else
        begin
            den = (pick < 40) ? $urandom_range(1, 255) : $urandom_range(1, FINE_MAX);
            r.cal_first = FINE_W'($urandom_range(0, FINE_MAX - den));
            r.cal_second = r.cal_first + FINE_W'(den);
        end
        r.time_start = random_fine();
        r.time_stop = random_fine();
        r.coarse_count = ($urandom_range(9) == 0) ? '1 : COARSE_W'($urandom);
        r.stop_index = ($urandom_range(3) == 0) ? STOP_W'($urandom_range(5, 7))
                                                : STOP_W'($urandom_range(0, 4));
        r.coarse_ovf = ($urandom_range(9) == 0);
        r.clock_ovf = ($urandom_range(9) == 0);
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_stop(input stop_req_t r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata = S_DATA_W'({r.clock_ovf, r.coarse_ovf, r.stop_index, r.coarse_count,
                             r.time_stop, r.time_start, r.cal_second, r.cal_first});
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_tofs.push_back(predict_tof(r));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_tofs.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_config(input logic [PERIOD_W-1:0] period, input logic [CODE_W-1:0] code,
                              input logic mode, input logic [STOP_W-1:0] stops);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = REG_PERIOD;
        cfg_data = CFG_W'(period);
        @(negedge clk);
        cfg_index = REG_CAL;
        cfg_data = CFG_W'(code);
        @(negedge clk);
        cfg_index = REG_MODE;
        cfg_data = CFG_W'(mode);
        @(negedge clk);
        cfg_index = REG_STOPS;
        cfg_data = CFG_W'(stops);
        @(negedge clk);
        cfg_we = 1'b0;
        period_r = period;
        cal_code_r = code;
        mode_two_r = mode;
        stop_count_r = stops;
    endtask

    // reset settings: bad calibration, overflow flags, full-scale mode 2
    task automatic test_calibration_errors();
        send_stop(make_stop('0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
        send_stop(make_stop('1, '0, '1, '0, '1, '0, 1'b1, 1'b1));
        send_stop(make_stop('0, 24'd1, '1, '0, '1, '0, 1'b0, 1'b0));
        send_stop(make_stop('0, 24'd1, '1, '0, '1, '0, 1'b1, 1'b0));
        send_stop(make_stop(24'd5, 24'd9, '0, '1, 16'd7, '0, 1'b0, 1'b1));
    endtask

    task automatic test_mode_two_extremes();
        set_config(20'd1000000, 2'd3, 1'b1, 3'd5);
        send_stop(make_stop('0, 24'd1, '1, '0, '1, 3'd4, 1'b0, 1'b0));
        send_stop(make_stop('0, 24'd1, '0, '1, '1, 3'd0, 1'b0, 1'b0));
        send_stop(make_stop('0, '1, 24'd1234, 24'd1234, '1, 3'd3, 1'b0, 1'b0));
        send_stop(make_stop('0, '1, 24'd100, 24'd200, 16'd3, 3'd4, 1'b0, 1'b0));
        // zero clock period
        set_config('0, 2'd2, 1'b1, 3'd1);
        send_stop(make_stop(24'd10, 24'd20, '1, 24'd3, '1, 3'd0, 1'b0, 1'b0));
    endtask

    task automatic test_mode_one();
        set_config(20'd20000, 2'd0, 1'b0, 3'd3);
        send_stop(make_stop('0, 24'd1, '0, '1, '1, 3'd2, 1'b0, 1'b0));
        send_stop(make_stop(24'd7, 24'd8, '1, '0, '1, 3'd1, 1'b0, 1'b0));
        send_stop(make_stop('0, '1, '1, '1, '0, 3'd2, 1'b1, 1'b0));
        set_config('1, 2'd3, 1'b0, 3'd5);
        send_stop(make_stop('0, 24'd1, '0, '1, '0, 3'd4, 1'b0, 1'b0));
    endtask

    task automatic test_stop_indexing();
        // stop counts of 0 and above the maximum behave as 1
        set_config(20'd83333, 2'd1, 1'b1, 3'd0);
        send_stop(make_stop('0, 24'd100, 24'd50, 24'd20, 16'd2, 3'd0, 1'b0, 1'b0));
        send_stop(make_stop('0, 24'd100, 24'd50, 24'd20, 16'd2, 3'd1, 1'b0, 1'b0));
        set_config(20'd83333, 2'd1, 1'b1, 3'd7);
        send_stop(make_stop('0, 24'd100, 24'd20, 24'd50, 16'd2, 3'd0, 1'b0, 1'b0));
        send_stop(make_stop('0, 24'd100, 24'd20, 24'd50, 16'd2, 3'd6, 1'b0, 1'b0));
        send_stop(make_stop('0, 24'd100, 24'd20, 24'd50, 16'd2, 3'd7, 1'b0, 1'b0));
        set_config(20'd83333, 2'd1, 1'b1, 3'd5);
        send_stop(make_stop('0, 24'd100, 24'd20, 24'd50, 16'd2, 3'd4, 1'b0, 1'b0));
        send_stop(make_stop('0, 24'd100, 24'd20, 24'd50, 16'd2, 3'd5, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        logic [PERIOD_W-1:0] period;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
            begin
                case ($urandom_range(5))
                    0:       period = 20'd20000;
                    1:       period = 20'd1000000;
                    2:       period = '0;
                    3:       period = '1;
                    default: period = PERIOD_W'($urandom_range(20000, 1000000));
                endcase
                set_config(period, CODE_W'($urandom_range(3)), 1'($urandom_range(1)),
                           STOP_W'($urandom_range(7)));
            end
            send_stop(random_stop());
        end
        wait_drained();
    endtask

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_results
        tof_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_tofs.size() == 0)
            begin
                $error("result with no request pending: tof_ps=%0d",
                       $signed(m_tdata[TOF_W-1:0]));
                mismatches++;
            end
            else
            begin
                want = pending_tofs.pop_front();
                if (m_tdata[TOF_W-1:0] !== want.tof_ps)
                begin
                    $error("tof_ps: expected %0d, got %0d", $signed(want.tof_ps),
                           $signed(m_tdata[TOF_W-1:0]));
                    mismatches++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== want.last_stop)
                begin
                    $error("last_stop: expected %0d, got %0d", want.last_stop, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PERIOD;
        cfg_data = '0;
        period_r = PERIOD_RST;
        cal_code_r = CAL_RST;
        mode_two_r = MODE_RST;
        stop_count_r = STOPS_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_calibration_errors();
        test_mode_two_extremes();
        test_mode_one();
        test_stop_indexing();
        test_random_traffic(0, 0, 100);
        test_random_traffic(81, 0, 100);
        test_random_traffic(0, 81, 100);
        test_random_traffic(32, 32, 100);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_tofs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
